[rtl/ogmc_pkg.sv]
// Package for the oxygen generator mode controller.
// Holds the payload structs, configuration struct, mode codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package ogmc_pkg;

	localparam int unsigned PhaseCount = 7;
	localparam int unsigned PhaseW = 3;
	localparam int unsigned DelayW = 10;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW = 10;

	localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(PhaseCount - 1);
	localparam logic [PhaseW-1:0] PhaseBoth = 3'd3;

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] CFG_PRESSURE_READY = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_PRESSURE_ALARM = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_O2_BAND = 2'd2;
	localparam logic [CfgIndexW-1:0] CFG_PUMP_OFF_DELAY = 2'd3;

	// Reported mode codes.
	localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_CODE_PRESS = 2'd1;
	localparam logic [1:0] MODE_CODE_RUN = 2'd2;

	// Internal mode register, one-hot.
	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_PRESS = 3'b010,
		MODE_RUN = 3'b100
	} mode_t;

	typedef struct packed {
		logic op;
		logic work_request;
		logic [6:0] o2_setpoint;
		logic [9:0] o2_measured;
		logic [7:0] gas_pressure;
	} in_t;

	typedef struct packed {
		logic generation_pump;
		logic ion_pump;
		logic alarm;
		logic lamp_one;
		logic lamp_two;
		logic sieve_one;
		logic sieve_two;
		logic [1:0] mode_now;
	} out_t;

	typedef struct packed {
		logic [7:0] pressure_ready;
		logic [7:0] pressure_alarm;
		logic [6:0] o2_band;
		logic [DelayW-1:0] pump_off_delay;
	} cfg_t;

endpackage

[rtl/ogmc_cfg.sv]
// Configuration register file of the oxygen generator mode controller.
// Depends on ogmc_pkg.
`timescale 1ns / 1ps

module ogmc_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ogmc_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [ogmc_pkg::CfgDataW-1:0] cfg_wdata,
	output ogmc_pkg::cfg_t cfg
);

	ogmc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressure_ready <= 8'd15;
			cfg_q.pressure_alarm <= 8'd5;
			cfg_q.o2_band <= 7'd2;
			cfg_q.pump_off_delay <= 10'd300;
		end else if (cfg_we) begin
			case (cfg_index)
				ogmc_pkg::CFG_PRESSURE_READY: cfg_q.pressure_ready <= cfg_wdata[7:0];
				ogmc_pkg::CFG_PRESSURE_ALARM: cfg_q.pressure_alarm <= cfg_wdata[7:0];
				ogmc_pkg::CFG_O2_BAND: cfg_q.o2_band <= cfg_wdata[6:0];
				ogmc_pkg::CFG_PUMP_OFF_DELAY: cfg_q.pump_off_delay <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/ogmc_core.sv]
// Control state and next-state logic of the oxygen generator mode controller.
// Updates mode, sieve and shutoff state on each accepted item. Depends on ogmc_pkg.
`timescale 1ns / 1ps

module ogmc_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  ogmc_pkg::in_t item,
	input  ogmc_pkg::cfg_t cfg,
	output ogmc_pkg::out_t result
);

	ogmc_pkg::mode_t mode_q, mode_d;
	logic sieve_active_q, sieve_active_d;
	logic sieve_started_q, sieve_started_d;
	logic [ogmc_pkg::PhaseW-1:0] phase_q, phase_d;
	logic armed_q, armed_d;
	logic [ogmc_pkg::DelayW-1:0] count_q, count_d;
	logic gen_q, gen_d, ion_q, ion_d, alarm_q, alarm_d;
	logic lamp1_q, lamp1_d, lamp2_q, lamp2_d, sv1_q, sv1_d, sv2_q, sv2_d;
	logic [10:0] low_sum;
	logic [1:0] mode_code;

	assign low_sum = {1'b0, item.o2_measured} + {4'd0, cfg.o2_band};

	always_comb begin
		mode_d = mode_q;
		sieve_active_d = sieve_active_q;
		sieve_started_d = sieve_started_q;
		phase_d = phase_q;
		armed_d = armed_q;
		count_d = count_q;
		gen_d = gen_q;
		ion_d = ion_q;
		alarm_d = alarm_q;
		lamp1_d = lamp1_q;
		lamp2_d = lamp2_q;
		sv1_d = sv1_q;
		sv2_d = sv2_q;
		if (item.op) begin
			if (sieve_active_q) begin
				if (!sieve_started_q) begin
					sieve_started_d = 1'b1;
					phase_d = ogmc_pkg::PhaseW'(1);
				end else begin
					phase_d = (phase_q == ogmc_pkg::PhaseLast) ? '0 : phase_q + 1'b1;
					if (phase_d < ogmc_pkg::PhaseBoth) begin
						sv1_d = 1'b0;
						sv2_d = 1'b1;
					end else if (phase_d == ogmc_pkg::PhaseBoth) begin
						sv1_d = 1'b1;
						sv2_d = 1'b1;
					end else begin
						sv1_d = 1'b1;
						sv2_d = 1'b0;
					end
				end
			end
			if (armed_q) begin
				if (count_q <= ogmc_pkg::DelayW'(1)) begin
					gen_d = 1'b0;
					armed_d = 1'b0;
					count_d = '0;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
		end else if (!item.work_request) begin
			alarm_d = 1'b0;
			lamp1_d = 1'b0;
			lamp2_d = 1'b0;
			ion_d = 1'b0;
			sv1_d = 1'b0;
			sv2_d = 1'b0;
			sieve_active_d = 1'b0;
			if (!armed_q && gen_q) begin
				armed_d = 1'b1;
				count_d = cfg.pump_off_delay;
			end
			mode_d = ogmc_pkg::MODE_IDLE;
		end else if (mode_q == ogmc_pkg::MODE_RUN) begin
			// Pump hysteresis: off above setpoint, on below setpoint minus band.
			if (item.o2_measured > {3'd0, item.o2_setpoint}) begin
				gen_d = 1'b0;
			end else if (low_sum < {4'd0, item.o2_setpoint}) begin
				gen_d = 1'b1;
			end
			if (item.gas_pressure < cfg.pressure_alarm) begin
				alarm_d = 1'b1;
				lamp1_d = 1'b1;
				lamp2_d = 1'b1;
			end else begin
				alarm_d = 1'b0;
			end
		end else begin
			armed_d = 1'b0;
			count_d = '0;
			gen_d = 1'b1;
			ion_d = 1'b1;
			if (item.gas_pressure < cfg.pressure_ready) begin
				alarm_d = 1'b1;
				lamp1_d = 1'b1;
				lamp2_d = 1'b1;
				mode_d = ogmc_pkg::MODE_PRESS;
			end else begin
				alarm_d = 1'b0;
				sieve_active_d = 1'b1;
				mode_d = ogmc_pkg::MODE_RUN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ogmc_pkg::MODE_IDLE;
			sieve_active_q <= 1'b0;
			sieve_started_q <= 1'b0;
			phase_q <= '0;
			armed_q <= 1'b0;
			count_q <= '0;
			gen_q <= 1'b0;
			ion_q <= 1'b0;
			alarm_q <= 1'b0;
			lamp1_q <= 1'b0;
			lamp2_q <= 1'b0;
			sv1_q <= 1'b0;
			sv2_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			sieve_active_q <= sieve_active_d;
			sieve_started_q <= sieve_started_d;
			phase_q <= phase_d;
			armed_q <= armed_d;
			count_q <= count_d;
			gen_q <= gen_d;
			ion_q <= ion_d;
			alarm_q <= alarm_d;
			lamp1_q <= lamp1_d;
			lamp2_q <= lamp2_d;
			sv1_q <= sv1_d;
			sv2_q <= sv2_d;
		end
	end

	always_comb begin
		case (mode_d)
			ogmc_pkg::MODE_PRESS: mode_code = ogmc_pkg::MODE_CODE_PRESS;
			ogmc_pkg::MODE_RUN: mode_code = ogmc_pkg::MODE_CODE_RUN;
			default: mode_code = ogmc_pkg::MODE_CODE_IDLE;
		endcase
	end

	// Result of the item being stepped: the levels after its update.
	assign result.generation_pump = gen_d;
	assign result.ion_pump = ion_d;
	assign result.alarm = alarm_d;
	assign result.lamp_one = lamp1_d;
	assign result.lamp_two = lamp2_d;
	assign result.sieve_one = sv1_d;
	assign result.sieve_two = sv2_d;
	assign result.mode_now = mode_code;

endmodule

[rtl/ogmc_outq.sv]
// Two-entry result queue of the oxygen generator mode controller.
// Lets the block take a new item while a result waits. Depends on ogmc_pkg.
`timescale 1ns / 1ps

module ogmc_outq (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ogmc_pkg::out_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output ogmc_pkg::out_t out_data
);

	ogmc_pkg::out_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign full = fill_q[1];
	assign out_valid = |fill_q;
	assign out_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/oxygen_generator_mode_control.sv]
// Top level of the oxygen generator mode controller.
// Instantiates ogmc_cfg, ogmc_core and ogmc_outq; depends on ogmc_pkg.
`timescale 1ns / 1ps

// Usage.
// Items arrive on the in channel (in_valid, in_ready, in_data). A control sample
// (op low) moves the mode between idle, pressurizing and running and drives the
// pumps, alarm and lamps; a one-second tick (op high) steps the sieve valve
// pattern and counts down the delayed pump shutoff armed by a stop request.
// Every transfer in produces exactly one transfer out on the out channel
// (out_valid, out_ready, out_data) holding all seven drive levels and the mode.
// The result of an accepted item is written into the result queue and offered
// from there. Throughput is one item per cycle while the queue has a free entry,
// set by the single pass of next-state logic between the state registers and
// the result queue. The result queue holds two entries, so an item is still
// taken while one finished result waits; in_ready drops only when both entries
// are occupied, which happens when the receiver stalls while items keep coming.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one register per
// cycle with no handshake; it is meant to be written while the block is idle.
// Reset (arst_n low) sets the mode to idle, all levels low, clears the sieve
// and shutoff state, empties the queue and loads the default configuration.

module oxygen_generator_mode_control (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ogmc_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ogmc_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [ogmc_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [ogmc_pkg::CfgDataW-1:0] cfg_wdata
);

	ogmc_pkg::cfg_t cfg;
	ogmc_pkg::out_t result;
	logic full;
	logic accept;

	// An item is taken whenever the queue has a free entry.
	assign in_ready = !full;
	assign accept = in_valid && in_ready;

	ogmc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	// State advances on the transfer; its updated levels go straight into the queue.
	ogmc_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.item(in_data),
		.cfg(cfg),
		.result(result)
	);

	ogmc_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_data(result),
		.full(full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
